// ===== rtl/scip_pkg.sv =====
// Shared types and constants for the sparse column inner product block.
`default_nettype none
package scip_pkg;
    localparam int NUM_COLUMNS = 4096;
    localparam int COL_W = 12;
    localparam int COL_AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int EPOCH_W = 8;

    typedef enum logic [2:0] {
        REQ_LEFT  = 3'd0,
        REQ_RIGHT = 3'd1,
        REQ_EOR   = 3'd2,
        REQ_READ  = 3'd3,
        REQ_START = 3'd4
    } t_req;

    // Classified request passed from front to back
    typedef struct packed {
        logic              is_left;
        logic              is_right;
        logic              is_eor;
        logic              is_read;
        logic              is_start;
        logic              in_range;
        logic [COL_W-1:0]  col;
        logic [31:0]       value;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ADD,
        ST_WAIT,
        ST_CLR
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/sparse_column_inner_product.sv =====
// Top level of the sparse column inner product block.
// A request is registered in the input queue before the back sequencer can take it.
// Left entry, end of row, start: taken in idle; right entry: read, multiply, add, write.
// A read goes through the read and wait states; results wait in a one-entry register.
// Reset is synchronous, active low; then a pass over all 4096 columns clears epoch tags,
// and a like pass stalls input after every 255th end of row and every 255th start.
`default_nettype none
module sparse_column_inner_product import scip_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [2:0]       i_req_type,
    input  wire logic [COL_W-1:0] i_col_index,
    input  wire logic signed [31:0] i_entry_value,
    output logic                  empty,
    input  wire logic             pop,
    output logic [COL_W-1:0]      o_col_out,
    output logic signed [63:0]    o_column_sum,
    output logic                  o_saturated,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_data
);
    logic r_square_mode;
    logic w_cmd_valid, w_cmd_take;
    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;
    // Hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_square_mode <= 1'b0;
        else if (i_cfg_valid) r_square_mode <= i_cfg_data;
    end

    scip_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_req_type, .i_col_index,
        .i_entry_value(i_entry_value), .o_cmd_valid(w_cmd_valid),
        .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    scip_back u_back (
        .i_clk, .i_rst_n, .i_square_mode(r_square_mode),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_take(w_cmd_take),
        .empty, .pop, .o_col_out, .o_column_sum, .o_saturated
    );
endmodule
`default_nettype wire

// ===== rtl/scip_front.sv =====
// Front end: accept requests, classify them and queue them for the back end.
`default_nettype none
module scip_front import scip_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [2:0]       i_req_type,
    input  wire logic [COL_W-1:0] i_col_index,
    input  wire logic [31:0]      i_entry_value,
    output logic                  o_cmd_valid,
    output t_cmd                  o_cmd,
    input  wire logic             i_cmd_take
);
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd n_cmd;
    logic w_push;

    assign full        = (r_cnt == 2'd2);
    assign w_push      = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Decode the request
    always_comb begin
        n_cmd = '0;
        n_cmd.col      = i_col_index;
        n_cmd.value    = i_entry_value;
        n_cmd.in_range = ({{(32-COL_W){1'b0}}, i_col_index} < 32'(NUM_COLUMNS));
        unique case (i_req_type)
            REQ_LEFT:  n_cmd.is_left  = 1'b1;
            REQ_RIGHT: n_cmd.is_right = 1'b1;
            REQ_EOR:   n_cmd.is_eor   = 1'b1;
            REQ_READ:  n_cmd.is_read  = 1'b1;
            REQ_START: n_cmd.is_start = 1'b1;
            default:   ;
        endcase
    end

    // Hold payload in the queue
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= n_cmd;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_take};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/scip_back.sv =====
// Back end: scratch row, accumulators, multiply and saturating add.
`default_nettype none
module scip_back import scip_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_square_mode,
    input  wire logic             i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_cmd_take,
    output logic                  empty,
    input  wire logic             pop,
    output logic [COL_W-1:0]      o_col_out,
    output logic signed [63:0]    o_column_sum,
    output logic                  o_saturated
);
    // Memories: epoch-tagged so clears are a counter bump; tag 0 is never live
    logic [31:0]        m_scr [NUM_COLUMNS];
    logic [EPOCH_W-1:0] m_scr_ep [NUM_COLUMNS];
    logic [63:0]        m_acc [NUM_COLUMNS];
    logic [EPOCH_W:0]   m_acc_ep [NUM_COLUMNS]; // {sat, epoch}

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [EPOCH_W-1:0] r_row_ep, r_acc_epoch;
    logic [31:0]        r_scr_rd;
    logic [EPOCH_W-1:0] r_scr_ep_rd;
    logic [63:0]        r_acc_rd;
    logic [EPOCH_W:0]   r_acc_ep_rd;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_sum;
    logic               r_sat, r_full;
    logic [COL_W-1:0]   r_col;
    logic               r_clr_scr, r_clr_acc;
    logic [COL_AW-1:0]  r_clr_addr;
    logic [COL_AW-1:0]  w_addr, w_caddr, w_sep_addr, w_aep_addr;
    logic               w_start_cmd, w_wr_scr, w_wr_acc, w_load_out;
    logic               w_clearing, w_clr_done, w_row_wrap, w_acc_wrap;
    logic               w_sep_we, w_aep_we;
    logic [EPOCH_W-1:0] w_sep_d;
    logic [EPOCH_W:0]   w_aep_d;
    logic signed [63:0] w_acc_in, w_sum, w_add;
    logic signed [31:0] w_other;
    logic               w_acc_ok, w_ovf, w_sat_new;

    assign w_caddr = i_cmd.col[COL_AW-1:0];
    assign w_addr  = r_cmd.col[COL_AW-1:0];
    assign empty   = !r_full;
    assign o_col_out    = r_col;
    assign o_column_sum = r_sum;
    assign o_saturated  = r_sat;

    assign w_clearing = (r_state == ST_CLR);
    assign w_clr_done = (r_clr_addr == COL_AW'(NUM_COLUMNS - 1));
    assign w_row_wrap = (r_row_ep == {EPOCH_W{1'b1}});
    assign w_acc_wrap = (r_acc_epoch == {EPOCH_W{1'b1}});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_cmd_valid) begin
                if ((i_cmd.is_right || i_cmd.is_read) && i_cmd.in_range) n_state = ST_READ;
                else if (i_cmd.is_read) n_state = ST_WAIT;
                else if ((i_cmd.is_eor && w_row_wrap) || (i_cmd.is_start && w_acc_wrap))
                    n_state = ST_CLR;
            end
            ST_READ: n_state = r_cmd.is_read ? ST_WAIT : ST_MUL;
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = ST_IDLE;
            ST_WAIT: if (!r_full || pop) n_state = ST_IDLE;
            ST_CLR:  if (w_clr_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_cmd_take = 1'b0;
        w_wr_scr = 1'b0;
        w_wr_acc = 1'b0;
        w_load_out = 1'b0;
        w_start_cmd = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_take = i_cmd_valid;
                w_wr_scr = i_cmd_valid && i_cmd.is_left && i_cmd.in_range;
                w_start_cmd = i_cmd_valid;
            end
            ST_ADD:  w_wr_acc = 1'b1;
            ST_WAIT: w_load_out = !r_full || pop;
            default: ;
        endcase
    end

    // Steer tag writes to the clearing pass while it runs
    assign w_sep_we   = w_clearing ? r_clr_scr : w_wr_scr;
    assign w_sep_addr = w_clearing ? r_clr_addr : w_caddr;
    assign w_sep_d    = w_clearing ? '0 : r_row_ep;
    assign w_aep_we   = w_clearing ? r_clr_acc : w_wr_acc;
    assign w_aep_addr = w_clearing ? r_clr_addr : w_addr;
    assign w_aep_d    = w_clearing ? '0 : {w_sat_new, r_acc_epoch};

    // Scratch and accumulator reads, captured when a request is taken
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_scr_rd    <= m_scr[w_caddr];
            r_scr_ep_rd <= m_scr_ep[w_caddr];
            r_acc_rd    <= m_acc[w_caddr];
            r_acc_ep_rd <= m_acc_ep[w_caddr];
        end
        if (w_wr_scr) m_scr[w_caddr] <= i_cmd.value;
        if (w_sep_we) m_scr_ep[w_sep_addr] <= w_sep_d;
        if (w_wr_acc) m_acc[w_addr] <= w_add;
        if (w_aep_we) m_acc_ep[w_aep_addr] <= w_aep_d;
    end

    // Multiply then add with saturation
    assign w_other  = i_square_mode ? $signed(r_cmd.value) :
                      (r_scr_ep_rd == r_row_ep ? $signed(r_scr_rd) : 32'sd0);
    assign w_acc_ok = (r_acc_ep_rd[EPOCH_W-1:0] == r_acc_epoch);
    assign w_acc_in = w_acc_ok ? $signed(r_acc_rd) : 64'sd0;
    assign w_sum    = w_acc_in + r_prod;
    assign w_ovf    = (w_acc_in[63] == r_prod[63]) && (w_sum[63] != w_acc_in[63]);
    assign w_add    = w_ovf ? (r_prod[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                            : w_sum;
    assign w_sat_new = w_ovf || (w_acc_ok && r_acc_ep_rd[EPOCH_W]);

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) r_cmd <= i_cmd;
        if (r_state == ST_MUL) r_prod <= $signed(r_cmd.value) * w_other;
        if (w_load_out) begin
            r_col <= r_cmd.col;
            r_sum <= (r_cmd.in_range && w_acc_ok) ? $signed(r_acc_rd) : 64'sd0;
            r_sat <= r_cmd.in_range && w_acc_ok && r_acc_ep_rd[EPOCH_W];
        end
    end

    // Control registers; epochs advance on end of row and start, and wrap via a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_full <= 1'b0;
            r_row_ep <= EPOCH_W'(1);
            r_acc_epoch <= EPOCH_W'(1);
            r_clr_scr <= 1'b1;
            r_clr_acc <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_load_out) r_full <= 1'b1;
            else if (pop) r_full <= 1'b0;
            if (w_clearing) begin
                if (w_clr_done) begin
                    r_clr_scr <= 1'b0;
                    r_clr_acc <= 1'b0;
                    r_clr_addr <= '0;
                end else begin
                    r_clr_addr <= r_clr_addr + COL_AW'(1);
                end
            end else begin
                if (w_start_cmd && i_cmd.is_eor) begin
                    if (w_row_wrap) begin
                        r_row_ep <= EPOCH_W'(1);
                        r_clr_scr <= 1'b1;
                    end else begin
                        r_row_ep <= r_row_ep + EPOCH_W'(1);
                    end
                end
                if (w_start_cmd && i_cmd.is_start) begin
                    if (w_acc_wrap) begin
                        r_acc_epoch <= EPOCH_W'(1);
                        r_clr_acc <= 1'b1;
                    end else begin
                        r_acc_epoch <= r_acc_epoch + EPOCH_W'(1);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/scip_checker.sv =====
// Port-level checker for the sparse column inner product block, with bind.
`default_nettype none
module scip_checker import scip_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             full,
    input wire logic             empty,
    input wire logic             pop,
    input wire logic [COL_W-1:0] o_col_out,
    input wire logic             o_saturated,
    input wire logic [63:0]      o_column_sum
);
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_col_out) && $stable(o_column_sum)
                              && $stable(o_saturated)))
        else $error("waiting result changed");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !$isunknown({o_col_out, o_column_sum, o_saturated}))
        else $error("unknown bits on a waiting result");
endmodule
bind sparse_column_inner_product scip_checker u_chk (
    .i_clk, .i_rst_n, .full, .empty, .pop,
    .o_col_out, .o_saturated, .o_column_sum
);
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the sparse column inner product block.
`timescale 1ns / 100ps
module testbench;
    import scip_pkg::*;

    localparam int          HALF_PERIOD = 4;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          NCOL        = 4096;
    localparam logic [2:0]  REQ_UNK5    = 3'd5;
    localparam logic [2:0]  REQ_UNK6    = 3'd6;
    localparam logic [2:0]  REQ_UNK7    = 3'd7;
    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [2:0]             i_req_type = REQ_EOR;
    logic [COL_W-1:0]       i_col_index = '0;
    logic signed [31:0]     i_entry_value = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [COL_W-1:0]       o_col_out;
    logic signed [63:0]     o_column_sum;
    logic                   o_saturated;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data = 1'b0;

    sparse_column_inner_product u_dut (
        .i_clk, .i_rst_n, .push, .full, .i_req_type, .i_col_index, .i_entry_value,
        .empty, .pop, .o_col_out, .o_column_sum, .o_saturated,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Expected read result
    typedef struct {
        logic [COL_W-1:0]   col;
        logic signed [63:0] sum;
        logic               sat;
    } t_sum_exp;

    // Directed stimulus row: either a request or a mode change
    typedef struct {
        bit                 is_cfg;
        logic [2:0]         req;
        logic [COL_W-1:0]   col;
        logic [31:0]        val;
        bit                 typed;
        logic signed [63:0] sum;
        logic               sat;
    } t_row;

    // Shadow copy of the column store
    logic [31:0]        row_val [NCOL];
    bit                 row_ok  [NCOL];
    logic signed [63:0] col_acc [NCOL];
    bit                 acc_ok  [NCOL];
    bit                 acc_sat [NCOL];
    bit                 sq_mode;

    t_sum_exp   sum_q[$];
    int         errors   = 0;
    int         n_items  = 0;
    int         n_reads  = 0;
    int         n_sats   = 0;
    int         cycles   = 0;
    bit         calm     = 1'b0;
    bit         hold_req = 1'b0;
    bit         hold_seen = 1'b0;

    // Update the shadow store for one request; return 1 with the read result
    function automatic bit model_request(input logic [2:0] req, input logic [COL_W-1:0] col,
                                         input logic [31:0] val, output t_sum_exp res);
        logic signed [63:0] other;
        logic signed [63:0] prod;
        logic signed [64:0] tot;
        logic signed [63:0] acc;
        res = '{default: '0};
        case (req)
            REQ_LEFT: begin
                row_val[col] = val;
                row_ok[col]  = 1'b1;
            end
            REQ_RIGHT: begin
                if (sq_mode) other = 64'(signed'(val));
                else if (row_ok[col]) other = 64'(signed'(row_val[col]));
                else other = '0;
                prod = 64'(signed'(val)) * other;
                acc  = acc_ok[col] ? col_acc[col] : 64'sd0;
                tot  = 65'(acc) + 65'(prod);
                if (tot > 65'(SUM_MAX)) begin
                    acc = SUM_MAX;
                    acc_sat[col] = 1'b1;
                end else if (tot < 65'(SUM_MIN)) begin
                    acc = SUM_MIN;
                    acc_sat[col] = 1'b1;
                end else begin
                    acc = tot[63:0];
                end
                col_acc[col] = acc;
                acc_ok[col]  = 1'b1;
            end
            REQ_EOR: begin
                foreach (row_ok[k]) row_ok[k] = 1'b0;
            end
            REQ_READ: begin
                res.col = col;
                res.sum = acc_ok[col] ? col_acc[col] : 64'sd0;
                res.sat = acc_sat[col];
                return 1'b1;
            end
            REQ_START: begin
                foreach (acc_ok[k]) begin
                    acc_ok[k]  = 1'b0;
                    acc_sat[k] = 1'b0;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Offer one request, hold it until accepted; typed rows override the prediction
    task automatic send_request(input logic [2:0] req, input logic [COL_W-1:0] col,
                                input logic [31:0] val, input bit typed = 0,
                                input logic signed [63:0] tsum = 0, input logic tsat = 0);
        t_sum_exp res;
        while (!calm && $urandom_range(99) < 27) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_req_type    <= req;
        i_col_index   <= col;
        i_entry_value <= val;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_items++;
        if (model_request(req, col, val, res)) begin
            if (typed) begin
                res.sum = tsum;
                res.sat = tsat;
            end
            sum_q.push_back(res);
        end
        @(negedge i_clk);
    endtask

    // Drain, let trailing right entries retire, then change the mode
    task automatic write_mode(input bit m);
        push <= 1'b0;
        while (sum_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sq_mode = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return '1;
            4, 5: return $urandom_range(32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COL_W-1:0] pick_col(input logic [COL_W-1:0] base);
        if ($urandom_range(9) == 0) return COL_W'($urandom);
        return base + COL_W'($urandom_range(7));
    endfunction

    // Random rows: mostly well-formed, some noise and broken rows
    task automatic random_rows(input int n, input logic [COL_W-1:0] base);
        int stop;
        logic [COL_W-1:0] c;
        stop = n_items + n;
        while (n_items < stop) begin
            if ($urandom_range(19) == 0) send_request(REQ_START, COL_W'($urandom), $urandom);
            repeat ($urandom_range(4)) send_request(REQ_LEFT, pick_col(base), pick_value());
            repeat ($urandom_range(1, 4)) begin
                c = pick_col(base);
                send_request(REQ_RIGHT, c, pick_value());
                if ($urandom_range(2) == 0) send_request(REQ_READ, c, $urandom);
            end
            if ($urandom_range(9) == 0)
                send_request(3'($urandom_range(5, 7)), COL_W'($urandom), $urandom);
            repeat ($urandom_range(2)) send_request(REQ_READ, pick_col(base), $urandom);
            // leave the row open now and then
            if ($urandom_range(9) != 0) send_request(REQ_EOR, COL_W'($urandom), $urandom);
        end
    endtask

    t_row dir_tab[] = '{
        '{0, REQ_READ,  12'd0,    32'd0,       1, 64'sd0,  1'b0},
        '{0, REQ_READ,  12'd4095, 32'd0,       1, 64'sd0,  1'b0},
        '{0, REQ_LEFT,  12'd4095, VAL_MAX,     0, 64'sd0,  1'b0},
        '{0, REQ_LEFT,  12'd4095, VAL_MIN,     0, 64'sd0,  1'b0},
        '{0, REQ_RIGHT, 12'd4095, VAL_MIN,     0, 64'sd0,  1'b0},
        '{0, REQ_RIGHT, 12'd4095, VAL_MIN,     0, 64'sd0,  1'b0},
        '{0, REQ_READ,  12'd4095, 32'd0,       1, SUM_MAX, 1'b1},
        '{0, REQ_RIGHT, 12'd4095, VAL_MAX,     0, 64'sd0,  1'b0},
        '{0, REQ_READ,  12'd4095, 32'd0,       0, 64'sd0,  1'b0},
        '{0, REQ_LEFT,  12'd7,    VAL_MIN,     0, 64'sd0,  1'b0},
        '{0, REQ_RIGHT, 12'd7,    VAL_MAX,     0, 64'sd0,  1'b0},
        '{0, REQ_RIGHT, 12'd7,    VAL_MAX,     0, 64'sd0,  1'b0},
        '{0, REQ_RIGHT, 12'd7,    VAL_MAX,     0, 64'sd0,  1'b0},
        '{0, REQ_READ,  12'd7,    32'd0,       1, SUM_MIN, 1'b1},
        '{0, REQ_EOR,   12'd0,    32'd0,       0, 64'sd0,  1'b0},
        '{0, REQ_RIGHT, 12'd4095, 32'h0001_2345, 0, 64'sd0, 1'b0},
        '{0, REQ_READ,  12'd4095, 32'd0,       0, 64'sd0,  1'b0},
        '{0, REQ_UNK5,  12'd4095, '1,          0, 64'sd0,  1'b0},
        '{0, REQ_UNK6,  12'd0,    32'd0,       0, 64'sd0,  1'b0},
        '{0, REQ_UNK7,  12'd1,    VAL_MIN,     0, 64'sd0,  1'b0},
        '{0, REQ_START, 12'd0,    32'd0,       0, 64'sd0,  1'b0},
        '{0, REQ_READ,  12'd4095, 32'd0,       1, 64'sd0,  1'b0},
        '{1, REQ_EOR,   12'd1,    32'd0,       0, 64'sd0,  1'b0},
        '{0, REQ_LEFT,  12'd1,    32'd5,       0, 64'sd0,  1'b0},
        '{0, REQ_RIGHT, 12'd1,    VAL_MIN,     0, 64'sd0,  1'b0},
        '{0, REQ_RIGHT, 12'd1,    VAL_MIN,     0, 64'sd0,  1'b0},
        '{0, REQ_READ,  12'd1,    32'd0,       1, SUM_MAX, 1'b1},
        '{0, REQ_RIGHT, 12'd2,    '1,          0, 64'sd0,  1'b0},
        '{0, REQ_READ,  12'd2,    32'd0,       0, 64'sd0,  1'b0},
        '{1, REQ_EOR,   12'd0,    32'd0,       0, 64'sd0,  1'b0}
    };

    // Sender: reset, directed table, then random phases across both modes
    initial begin
        bit modes[5];
        modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        foreach (row_ok[k]) begin
            row_ok[k]  = 1'b0;
            acc_ok[k]  = 1'b0;
            acc_sat[k] = 1'b0;
        end
        sq_mode = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_cfg) write_mode(dir_tab[r].col[0]);
            else send_request(dir_tab[r].req, dir_tab[r].col, dir_tab[r].val,
                              dir_tab[r].typed, dir_tab[r].sum, dir_tab[r].sat);
        end

        foreach (modes[p]) begin
            write_mode(modes[p]);
            calm = (p == 3);
            if (p == 2) hold_req = 1'b1;
            random_rows(80, COL_W'($urandom));
        end
        calm = 1'b0;
        push <= 1'b0;

        // Wait for the last reads, then let the pipeline settle
        while (sum_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d requests in both modes, %0d reads checked, %0d saturated.",
                 n_items, n_reads, n_sats);
        $display("Receiver hold-off exercised: %0d.", hold_seen);
        if (errors == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

    // Receiver: random pop, one long hold-off to back the block up
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else begin
                pop <= calm || ($urandom_range(99) >= 27);
            end
        end
    end

    // Compare each popped result with the oldest expectation
    always @(posedge i_clk) begin
        t_sum_exp e;
        if (i_rst_n && pop && !empty) begin
            if (sum_q.size() == 0) begin
                $error("result for column %0d with none expected", o_col_out);
                errors++;
            end else begin
                e = sum_q.pop_front();
                n_reads++;
                if (e.sat) n_sats++;
                if (o_col_out !== e.col) begin
                    $error("col_out: expected %0d, got %0d", e.col, o_col_out);
                    errors++;
                end
                if (o_column_sum !== e.sum) begin
                    $error("column_sum: expected %0h, got %0h", e.sum, o_column_sum);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated: expected %0b, got %0b", e.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reads still expected.",
                     cycles, sum_q.size());
            $display("testbench NOT OK");
            $finish;
        end
    end
endmodule
